// ----- rtl/swmf_pkg.sv -----
`default_nettype none

package swmf_pkg;

  // Window depth, legal range 2..32.
  localparam int unsigned WindowLen = 8;
  localparam int unsigned SampleW   = 12;
  localparam int unsigned AgeW      = (WindowLen > 1) ? $clog2(WindowLen) : 1;

  // Ranks whose mean forms the result, counted from the smallest.
  localparam int unsigned RankLo = WindowLen / 2 - 1;
  localparam int unsigned RankHi = WindowLen / 2;

  localparam logic [AgeW-1:0] AgeOldest = AgeW'(WindowLen - 1);

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [AgeW-1:0]    age_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    sample_t val;     // stored sample
    age_t    age;     // transfers since it entered
    logic    gt;      // stored sample is above the incoming one
    logic    ev_pre;  // oldest entry sits at this cell or below
  } link_t;

endpackage

`default_nettype wire

// ----- rtl/swmf_sample_if.sv -----
`default_nettype none

interface swmf_sample_if;
  logic              valid;
  logic              ready;
  swmf_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/swmf_median_if.sv -----
`default_nettype none

interface swmf_median_if;
  logic              valid;
  logic              ready;
  swmf_pkg::sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

// ----- rtl/swmf_cell.sv -----
`default_nettype none

// One slot of the sorted window. On a shift it drops out the oldest entry
// (closing the gap) and makes room for the new sample, picking its next
// content from itself, a neighbor or the incoming sample.
module swmf_cell (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    shift_i,
  input  wire swmf_pkg::sample_t sample_i,
  input  wire swmf_pkg::age_t    rst_age_i,
  input  wire swmf_pkg::link_t   left_i,
  input  wire swmf_pkg::link_t   right_i,
  output swmf_pkg::link_t        link_o
);

  swmf_pkg::sample_t val_q, val_d;
  swmf_pkg::age_t    age_q, age_d;
  logic              gt;
  logic              ev;
  logic              passed;
  swmf_pkg::sample_t up_val, lo_val;
  swmf_pkg::age_t    up_age, lo_age;
  logic              up_gt, lo_gt;

  assign gt = (val_q > sample_i);
  assign ev = (age_q == swmf_pkg::AgeOldest);

  always_comb begin
    passed = left_i.ev_pre;
    // Compacted window with the oldest entry removed: slot above and below.
    if (passed || ev) begin
      up_val = right_i.val;
      up_age = right_i.age;
      up_gt  = right_i.gt;
    end else begin
      up_val = val_q;
      up_age = age_q;
      up_gt  = gt;
    end
    if (passed) begin
      lo_val = val_q;
      lo_age = age_q;
      lo_gt  = gt;
    end else begin
      lo_val = left_i.val;
      lo_age = left_i.age;
      lo_gt  = left_i.gt;
    end

    if (!up_gt) begin
      val_d = up_val;
      age_d = up_age + 1'b1;
    end else if (lo_gt) begin
      val_d = lo_val;
      age_d = lo_age + 1'b1;
    end else begin
      val_d = sample_i;
      age_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= rst_age_i;
    end else if (shift_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign link_o.val    = val_q;
  assign link_o.age    = age_q;
  assign link_o.gt     = gt;
  assign link_o.ev_pre = left_i.ev_pre | ev;

endmodule

`default_nettype wire

// ----- rtl/sliding_window_median_filter_core.sv -----
`default_nettype none

// Channel    Dir  Payload        Transfer
// sample_i   in   sample[11:0]   valid & ready
// median_o   out  median[11:0]   valid & ready
//
// One sample per cycle unless a held result waits on median_o: each
// transfer updates the sorted cell chain and the result shows the next
// cycle from the middle cells.
// Reset clears all window entries to zero, with distinct ages per cell.
// A held result stalls input only if median_o is not ready; a sample is
// taken in the same cycle the pending result transfers.
module sliding_window_median_filter_core (
  input  wire           clk_i,
  input  wire           rst_ni,
  swmf_sample_if.sink   sample_i,
  swmf_median_if.source median_o
);

  localparam int unsigned N = swmf_pkg::WindowLen;

  swmf_pkg::link_t links [N];
  swmf_pkg::link_t left_edge, right_edge;
  logic            accept;
  logic            out_valid_q, out_valid_d;
  logic [swmf_pkg::SampleW:0] mid_sum;
  logic [N-1:0]    ev_vec;
  logic [N-2:0]    ordered;

  assign accept         = sample_i.valid && sample_i.ready;
  assign sample_i.ready = !out_valid_q || median_o.ready;

  // Chain ends: nothing below the first cell, a "greater" sentinel above
  // the last so the top cell never pulls from beyond the window.
  assign left_edge  = '{val: '0, age: '0, gt: 1'b0, ev_pre: 1'b0};
  assign right_edge = '{val: '0, age: '0, gt: 1'b1, ev_pre: 1'b0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    swmf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (accept),
      .sample_i  (sample_i.sample),
      .rst_age_i (swmf_pkg::AgeW'(i)),
      .left_i    ((i == 0) ? left_edge : links[(i == 0) ? 0 : i - 1]),
      .right_i   ((i == N - 1) ? right_edge : links[(i == N - 1) ? i : i + 1]),
      .link_o    (links[i])
    );
    assign ev_vec[i] = (links[i].age == swmf_pkg::AgeOldest);
  end

  for (genvar i = 1; i < N; i++) begin : g_ord
    assign ordered[i-1] = (links[i-1].val <= links[i].val);
  end

  // Output holds a result until it transfers; the chain only moves on an
  // input transfer, so the middle cells stay put while it waits.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (median_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign mid_sum = {1'b0, links[swmf_pkg::RankLo].val}
                 + {1'b0, links[swmf_pkg::RankHi].val};

  assign median_o.valid  = out_valid_q;
  assign median_o.median = mid_sum[swmf_pkg::SampleW:1];

  // Exactly one cell holds the oldest entry.
  a_one_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(ev_vec))
    else $error("oldest entry not unique");

  // The chain stays sorted.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &ordered)
    else $error("window chain out of order");

  // Every accepted sample yields a pending result.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> median_o.valid)
    else $error("no result after sample");

  // Without a transfer the chain does not move.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(links[0].val) && $stable(links[N-1].age))
    else $error("chain moved without transfer");

endmodule

`default_nettype wire
